// ===== hw/rtl/vbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vbcm_pkg
// Shared types and codes for the versioned buffer copy manager.
// ----------------------------------------------------------------------------
package vbcm_pkg;

    // Copy bookkeeping sizes
    localparam int MAX_COPIES = 4;
    localparam int COPY_W     = 2;    // width of a copy index
    localparam int COUNT_W    = 3;    // width of copies_in_use
    localparam int READERS_W  = 8;    // reader count per copy
    localparam int STAMP_W    = 32;

    // Stream widths
    localparam int S_DATA_W = 8;      // copy_index, padded to a byte
    localparam int S_USER_W = 3;      // kind
    localparam int M_DATA_W = 40;     // status, granted_index, version_stamp

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNCONTROLLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPIES       = 1'd1;

    // Request kinds
    localparam logic [2:0] KIND_WRITE_ACQ = 3'd0;
    localparam logic [2:0] KIND_PUBLISH   = 3'd1;
    localparam logic [2:0] KIND_READ_ACQ  = 3'd2;
    localparam logic [2:0] KIND_READ_REL  = 3'd3;
    localparam logic [2:0] KIND_REINIT    = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_INIT = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_BAD      = 2'd3;

    typedef logic [READERS_W-1:0] readers_t;

endpackage

// ===== hw/rtl/versioned_buffer_copy_manager.sv =====
// An input transfer passes the input register, then the result register.
// Throughput: one request per cycle while results are taken; a new request
// is taken while a result waits only when the input register is empty.
// Reset (rst_n low, asynchronous): all copies free, nothing current, stamp 0,
// uncontrolled_mode = 0, copies_in_use = 4.
// ----------------------------------------------------------------------------
// versioned_buffer_copy_manager
// Tracks current, claimed and reader-held copies of a versioned buffer store.
// ----------------------------------------------------------------------------
module versioned_buffer_copy_manager (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [vbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vbcm_pkg::CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vbcm_pkg::S_DATA_W-1:0]   s_tdata,   // [1:0] copy_index
    input  logic [vbcm_pkg::S_USER_W-1:0]   s_tuser,   // [2:0] kind
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vbcm_pkg::M_DATA_W-1:0]   m_tdata    // [1:0] status,
                                                       // [3:2] granted_index,
                                                       // [35:4] version_stamp
);
    import vbcm_pkg::*;

    // Configuration registers
    logic                 uncontrolled_reg;
    logic [COUNT_W-1:0]   copies_reg;

    // Input register
    logic                 in_valid_reg;
    logic [2:0]           in_kind_reg;
    logic [COPY_W-1:0]    in_idx_reg;

    // Bookkeeping state
    logic [COPY_W-1:0]    cur_reg, cur_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [STAMP_W-1:0]   stamp_reg, stamp_next;
    logic [MAX_COPIES-1:0] claimed_reg, claimed_next;
    logic [MAX_COPIES-1:0] pending_reg, pending_next;
    readers_t             rc_reg [MAX_COPIES];
    readers_t             rc_next [MAX_COPIES];

    // Result register
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg, status_next;
    logic [COPY_W-1:0]    out_grant_reg, grant_next;
    logic [STAMP_W-1:0]   out_stamp_reg;

    logic                 advance;
    logic [COUNT_W-1:0]   n_eff;
    logic                 idx_ok;
    logic                 found;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uncontrolled_reg <= 1'b0;
            copies_reg       <= COUNT_W'(MAX_COPIES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNCONTROLLED: uncontrolled_reg <= cfg_data[0];
                CFG_COPIES:       copies_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Effective copy count, clamped to 1..MAX_COPIES
    always_comb
    begin
        if (copies_reg == '0)
            n_eff = COUNT_W'(1);
        else if (copies_reg > COUNT_W'(MAX_COPIES))
            n_eff = COUNT_W'(MAX_COPIES);
        else
            n_eff = copies_reg;
    end

    assign idx_ok = {1'b0, in_idx_reg} < n_eff;

    // Request decode and state update
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        stamp_next     = stamp_reg;
        claimed_next   = claimed_reg;
        pending_next   = pending_reg;
        rc_next        = rc_reg;
        status_next    = ST_BAD;
        grant_next     = '0;
        found          = 1'b0;

        unique case (in_kind_reg)
            KIND_WRITE_ACQ:
            begin
                // first free copy below the effective count
                status_next = ST_NO_FREE;
                for (int i = 0; i < MAX_COPIES; i++)
                begin
                    if (!found && !claimed_reg[i] && (COUNT_W'(i) < n_eff))
                    begin
                        found           = 1'b1;
                        claimed_next[i] = 1'b1;
                        status_next     = ST_OK;
                        grant_next      = COPY_W'(i);
                    end
                end
            end
            KIND_PUBLISH:
            begin
                if (idx_ok && claimed_reg[in_idx_reg] &&
                    !(cur_valid_reg && cur_reg == in_idx_reg))
                begin
                    // retire the old current copy, or defer until readers leave
                    if (cur_valid_reg)
                    begin
                        if (rc_reg[cur_reg] == '0)
                            claimed_next[cur_reg] = 1'b0;
                        else
                            pending_next[cur_reg] = 1'b1;
                    end
                    pending_next[in_idx_reg] = 1'b0;
                    cur_next       = in_idx_reg;
                    cur_valid_next = 1'b1;
                    stamp_next     = stamp_reg + STAMP_W'(1);
                    status_next    = ST_OK;
                end
            end
            KIND_READ_ACQ:
            begin
                if (!cur_valid_reg)
                    status_next = ST_NOT_INIT;
                else if (rc_reg[cur_reg] != '1)
                begin
                    rc_next[cur_reg] = rc_reg[cur_reg] + READERS_W'(1);
                    status_next      = ST_OK;
                    grant_next       = cur_reg;
                end
            end
            KIND_READ_REL:
            begin
                if (idx_ok && rc_reg[in_idx_reg] != '0)
                begin
                    // last reader of a superseded copy frees it
                    if (pending_reg[in_idx_reg] && rc_reg[in_idx_reg] == READERS_W'(1))
                    begin
                        claimed_next[in_idx_reg] = 1'b0;
                        pending_next[in_idx_reg] = 1'b0;
                    end
                    rc_next[in_idx_reg] = rc_reg[in_idx_reg] - READERS_W'(1);
                    status_next = ST_OK;
                end
            end
            KIND_REINIT:
            begin
                claimed_next   = '0;
                pending_next   = '0;
                for (int i = 0; i < MAX_COPIES; i++)
                    rc_next[i] = '0;
                stamp_next     = '0;
                cur_next       = '0;
                cur_valid_next = uncontrolled_reg;
                status_next    = ST_OK;
            end
            default: ;
        endcase
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg <= s_tuser;
            in_idx_reg  <= s_tdata[COPY_W-1:0];
        end
    end

    // Bookkeeping state, updated as a request moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            stamp_reg     <= '0;
            claimed_reg   <= '0;
            pending_reg   <= '0;
            for (int i = 0; i < MAX_COPIES; i++)
                rc_reg[i] <= '0;
        end
        else if (advance)
        begin
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            stamp_reg     <= stamp_next;
            claimed_reg   <= claimed_next;
            pending_reg   <= pending_next;
            rc_reg        <= rc_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg <= status_next;
            out_grant_reg  <= grant_next;
            out_stamp_reg  <= stamp_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_stamp_reg, out_grant_reg, out_status_reg};

endmodule

// ===== hw/rtl/vbcm_checker.sv =====
// ----------------------------------------------------------------------------
// vbcm_checker
// Port-level checks for the versioned buffer copy manager.
// ----------------------------------------------------------------------------
module vbcm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_we,
    input logic [vbcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [vbcm_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [vbcm_pkg::S_DATA_W-1:0]   s_tdata,
    input logic [vbcm_pkg::S_USER_W-1:0]   s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vbcm_pkg::M_DATA_W-1:0]   m_tdata
);
    import vbcm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A failed request grants nothing
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[3:2] == '0)
        else $error("grant on failed request");

    // Nothing current means no publish since initialization
    a_not_init_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_NOT_INIT |-> m_tdata[35:4] == '0)
        else $error("not initialized with nonzero stamp");

    // Pad bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:36] == '0)
        else $error("result pad bits set");

endmodule

bind versioned_buffer_copy_manager vbcm_checker u_vbcm_checker (.*);

// ===== verif/tb_versioned_buffer_copy_manager.sv =====
// ----------------------------------------------------------------------------
// tb_versioned_buffer_copy_manager
// Self-checking bench for the versioned buffer copy manager. A copy ledger
// class tracks claims and reader counts of every copy and the version stamp,
// and predicts the reply to each accepted request. Short directed sequences
// and a reader saturation run come first. Random phases then follow, each
// under its own register setting. Both streams stall at random, except in
// the final phase.
// ----------------------------------------------------------------------------
module tb_versioned_buffer_copy_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import vbcm_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int PHASE_ITEMS = 165;
    localparam int PHASES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_READERS = (1 << READERS_W) - 1;
    localparam longint TIMEOUT_NS = 20_000_000;
    // kinds above reinitialise are undefined requests
    localparam logic [2:0] KIND_FIRST_UNKNOWN = KIND_REINIT + 3'd1;

    // reply fields, highest bits first as on m_tdata
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [COPY_W-1:0]  granted;
        logic [1:0]         status;
    } reply_t;

    // ------------------------------------------------------------------------
    // Copy ledger: predicted state of the block and the replies still due
    // ------------------------------------------------------------------------
    class copy_ledger;
        logic               unctl_mode;
        logic [COUNT_W-1:0] copies_reg;
        logic [COPY_W-1:0]  cur_copy;
        logic               cur_valid;
        logic [STAMP_W-1:0] stamp;
        logic               claimed [MAX_COPIES];
        logic               release_due [MAX_COPIES];
        readers_t           readers [MAX_COPIES];
        reply_t             replies_due [$];
        int                 fails;

        function new();
            unctl_mode = 1'b0;
            copies_reg = COUNT_W'(MAX_COPIES);
            fails = 0;
            clear_copies();
        endfunction

        function void clear_copies();
            for (int i = 0; i < MAX_COPIES; i++)
            begin
                claimed[i] = 1'b0;
                release_due[i] = 1'b0;
                readers[i] = '0;
            end
            stamp = '0;
            cur_copy = '0;
            cur_valid = 1'b0;
        endfunction

        // copies_in_use clamped to 1..MAX_COPIES
        function int active_count();
            if (copies_reg == 0)
                return 1;
            if (copies_reg > MAX_COPIES)
                return MAX_COPIES;
            return int'(copies_reg);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_UNCONTROLLED)
                unctl_mode = val[0];
            else if (idx == CFG_COPIES)
                copies_reg = COUNT_W'(val);
        endfunction

        // accepted request: update state and queue the reply it causes
        function void note_request(logic [2:0] kind, logic [COPY_W-1:0] idx);
            reply_t r;
            int n;
            n = active_count();
            r.status = ST_BAD;
            r.granted = '0;
            case (kind)
                KIND_WRITE_ACQ:
                begin
                    r.status = ST_NO_FREE;
                    for (int i = 0; i < n; i++)
                    begin
                        if (!claimed[i] && r.status != ST_OK)
                        begin
                            claimed[i] = 1'b1;
                            r.status = ST_OK;
                            r.granted = COPY_W'(i);
                        end
                    end
                end
                KIND_PUBLISH:
                begin
                    if (int'(idx) < n && claimed[idx] && !(cur_valid && cur_copy == idx))
                    begin
                        // old current copy is freed now or at its last reader
                        if (cur_valid)
                        begin
                            if (readers[cur_copy] == 0)
                                claimed[cur_copy] = 1'b0;
                            else
                                release_due[cur_copy] = 1'b1;
                        end
                        release_due[idx] = 1'b0;
                        cur_copy = idx;
                        cur_valid = 1'b1;
                        stamp = stamp + 1'b1;
                        r.status = ST_OK;
                    end
                end
                KIND_READ_ACQ:
                begin
                    if (!cur_valid)
                        r.status = ST_NOT_INIT;
                    else if (readers[cur_copy] < MAX_READERS)
                    begin
                        readers[cur_copy] = readers[cur_copy] + 1'b1;
                        r.status = ST_OK;
                        r.granted = cur_copy;
                    end
                end
                KIND_READ_REL:
                begin
                    if (int'(idx) < n && readers[idx] != 0)
                    begin
                        if (release_due[idx] && readers[idx] == 1)
                        begin
                            claimed[idx] = 1'b0;
                            release_due[idx] = 1'b0;
                            readers[idx] = '0;
                        end
                        else
                            readers[idx] = readers[idx] - 1'b1;
                        r.status = ST_OK;
                    end
                end
                KIND_REINIT:
                begin
                    clear_copies();
                    if (unctl_mode)
                    begin
                        cur_copy = '0;
                        cur_valid = 1'b1;
                    end
                    r.status = ST_OK;
                end
                default:
                    r.status = ST_BAD;
            endcase
            r.stamp = stamp;
            replies_due.push_back(r);
        endfunction

        function void flag(string what);
            fails++;
            if (fails <= MAX_REPORTS)
                $display("ERROR @%0t: %s", $time, what);
        endfunction

        // accepted reply: compare with the oldest one due
        function void check_reply(logic [M_DATA_W-1:0] data);
            reply_t got;
            reply_t want;
            got = data[$bits(reply_t)-1:0];
            if (replies_due.size() == 0)
            begin
                flag($sformatf("reply with none due: 0x%0h", data));
                return;
            end
            want = replies_due.pop_front();
            if (got.status != want.status)
                flag($sformatf("status expected %0d got %0d", want.status, got.status));
            if (got.granted != want.granted)
                flag($sformatf("granted_index expected %0d got %0d",
                               want.granted, got.granted));
            if (got.stamp != want.stamp)
                flag($sformatf("version_stamp expected %0d got %0d", want.stamp, got.stamp));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;    // [1:0] copy_index
    logic [S_USER_W-1:0]   s_tuser = '0;    // [2:0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [1:0] status, [3:2] granted_index,
                                            // [35:4] version_stamp

    copy_ledger ledger = new();
    bit         idle_on = 1'b1;
    int         stall_left = 0;

    // register settings of the random phases, extremes included
    logic [CFG_DATA_W-1:0] mode_plan [PHASES] = '{3'd0, 3'd1, 3'd6, 3'd7, 3'd2, 3'd1, 3'd3, 3'd0};
    logic [CFG_DATA_W-1:0] count_plan [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4};

    versioned_buffer_copy_manager i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Result side: check each transfer, stall in random bursts
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_reply(m_tdata);
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rst_n && idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Request side tasks
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [2:0] kind, input logic [COPY_W-1:0] idx);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= S_DATA_W'(idx);
        do @(posedge clk); while (!s_tready);
        ledger.note_request(kind, idx);
    endtask

    // hold requests until every reply is in, then let the pipeline settle
    task automatic wait_replies_done();
        s_tvalid <= 1'b0;
        while (ledger.replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        ledger.note_config(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed requests drawn from the predicted copy state
    function automatic void pick_request(output logic [2:0] kind, output logic [COPY_W-1:0] idx);
        int roll;
        int n;
        int picks [$];
        roll = $urandom_range(0, 99);
        n = ledger.active_count();
        idx = COPY_W'($urandom_range(0, MAX_COPIES - 1));
        if (roll < 15)
            kind = KIND_WRITE_ACQ;
        else if (roll < 35)
        begin
            kind = KIND_PUBLISH;
            for (int i = 0; i < n; i++)
                if (ledger.claimed[i] && !(ledger.cur_valid && ledger.cur_copy == i))
                    picks.push_back(i);
            if (picks.size() > 0 && $urandom_range(0, 9) != 0)
                idx = COPY_W'(picks[$urandom_range(0, picks.size() - 1)]);
        end
        else if (roll < 60)
            kind = KIND_READ_ACQ;
        else if (roll < 85)
        begin
            kind = KIND_READ_REL;
            for (int i = 0; i < n; i++)
                if (ledger.readers[i] != 0)
                    picks.push_back(i);
            if (picks.size() > 0 && $urandom_range(0, 9) != 0)
                idx = COPY_W'(picks[$urandom_range(0, picks.size() - 1)]);
        end
        else if (roll < 88)
            kind = KIND_REINIT;
        else if (roll < 93)
            kind = KIND_FIRST_UNKNOWN + 3'($urandom_range(0, 2));
        else
            kind = 3'($urandom_range(0, 7));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [2:0]        kind;
        logic [COPY_W-1:0] idx;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: nothing current, four copies
        send_request(KIND_READ_ACQ, 2'd0);          // not initialised
        send_request(KIND_PUBLISH, 2'd0);           // unclaimed publish
        send_request(KIND_READ_REL, 2'd0);          // release underflow
        send_request(KIND_FIRST_UNKNOWN, 2'd1);
        send_request(KIND_FIRST_UNKNOWN + 3'd1, 2'd2);
        send_request(KIND_FIRST_UNKNOWN + 3'd2, 2'd3);
        repeat (MAX_COPIES + 1) send_request(KIND_WRITE_ACQ, 2'd0);   // last finds none free
        send_request(KIND_PUBLISH, 2'd0);
        send_request(KIND_PUBLISH, 2'd0);           // already current
        send_request(KIND_READ_ACQ, 2'd3);
        send_request(KIND_PUBLISH, 2'd1);           // old copy held: release pending
        send_request(KIND_READ_REL, 2'd0);          // last reader frees it
        send_request(KIND_WRITE_ACQ, 2'd3);
        send_request(KIND_PUBLISH, 2'd3);
        send_request(KIND_READ_REL, 2'd3);
        send_request(KIND_REINIT, 2'd0);
        wait_replies_done();

        // uncontrolled mode, two copies
        write_reg(CFG_COPIES, 3'd2);
        write_reg(CFG_UNCONTROLLED, 3'd1);
        send_request(KIND_REINIT, 2'd3);
        send_request(KIND_READ_ACQ, 2'd0);          // copy zero current from start
        send_request(KIND_WRITE_ACQ, 2'd0);         // copy zero still claimable
        send_request(KIND_WRITE_ACQ, 2'd0);
        send_request(KIND_WRITE_ACQ, 2'd0);
        send_request(KIND_PUBLISH, 2'd3);           // beyond copy count
        send_request(KIND_PUBLISH, 2'd1);
        send_request(KIND_READ_REL, 2'd2);          // beyond copy count
        wait_replies_done();

        // saturate the reader count of the current copy
        write_reg(CFG_COPIES, 3'd4);
        send_request(KIND_REINIT, 2'd0);
        repeat (MAX_READERS + 2) send_request(KIND_READ_ACQ, 2'd0);
        repeat (3) send_request(KIND_READ_REL, 2'd0);
        send_request(KIND_READ_ACQ, 2'd0);
        wait_replies_done();

        // random phases, no idling in the last one
        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p != PHASES - 1);
            write_reg(CFG_UNCONTROLLED, mode_plan[p]);
            write_reg(CFG_COPIES, count_plan[p]);
            send_request(KIND_REINIT, 2'd0);
            repeat (PHASE_ITEMS)
            begin
                pick_request(kind, idx);
                send_request(kind, idx);
            end
            wait_replies_done();
        end

        if (ledger.fails == 0 && ledger.replies_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("ERROR: timeout with %0d replies due", ledger.replies_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== versioned_buffer_copy_manager.f =====
hw/rtl/vbcm_pkg.sv
hw/rtl/versioned_buffer_copy_manager.sv
hw/rtl/vbcm_checker.sv
verif/tb_versioned_buffer_copy_manager.sv
